/* rtl/mws_pkg.sv */
// Shared types and constants for the max_window_sum_2d block.
// No dependencies; compile first.
package mws_pkg;

  localparam int unsigned DefMaxRows = 64;
  localparam int unsigned DefMaxCols = 64;

  localparam int unsigned CellW    = 16;
  localparam int unsigned SumW     = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;

  localparam logic signed [SumW-1:0] IntMin = {1'b1, {(SumW-1){1'b0}}};

  localparam logic [CfgDataW-1:0] GridHeightRst   = 7'd64;
  localparam logic [CfgDataW-1:0] GridWidthRst    = 7'd64;
  localparam logic [CfgDataW-1:0] WindowHeightRst = 7'd1;
  localparam logic [CfgDataW-1:0] WindowWidthRst  = 7'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRID_HEIGHT   = 3'd0,
    CFG_GRID_WIDTH    = 3'd1,
    CFG_WINDOW_HEIGHT = 3'd2,
    CFG_WINDOW_WIDTH  = 3'd3
  } cfg_idx_e;

  // Per-cell position flags, computed at accept and carried down the pipe.
  typedef struct packed {
    logic r_gt0;    // a row above exists
    logic c_gt0;    // a column to the left exists
    logic r_ge_wh;  // prefix row r-wh lies inside the grid
    logic c_ge_ww;  // strip column c-ww lies inside the grid
    logic win_ok;   // cell closes a full window
    logic last;     // last cell of the grid
  } mws_flags_t;

endpackage

/* rtl/mws_if.sv */
// Valid/ready channel interfaces for cells in and results out.
// Depends on mws_pkg.
interface mws_cell_if;
  import mws_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CellW-1:0] cell_value;
  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface mws_result_if;
  import mws_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [SumW-1:0] best_sum;
  logic                   window_found;
  modport source (output valid, output best_sum, output window_found, input ready);
  modport sink   (input valid, input best_sum, input window_found, output ready);
endinterface

/* rtl/mws_prefix.sv */
// Prefix-sum pipeline: row prefix, summed-area table, vertical strip sums.
// Holds the prefix memory and the strip line buffer. Depends on mws_pkg.
module mws_prefix #(
  parameter int unsigned MAX_ROWS = mws_pkg::DefMaxRows,
  parameter int unsigned MAX_COLS = mws_pkg::DefMaxCols,
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    acc_i,
  input  logic signed [mws_pkg::CellW-1:0]        cell_i,
  input  logic [RW-1:0]                           row_i,
  input  logic [CW-1:0]                           col_i,
  input  logic [RW-1:0]                           far_row_i,
  input  logic [CW-1:0]                           old_col_i,
  input  mws_pkg::mws_flags_t                     flags_i,
  output logic                                    e_valid_o,
  output logic signed [mws_pkg::SumW-1:0]         e_q_o,
  output logic signed [mws_pkg::SumW-1:0]         e_qold_o,
  output mws_pkg::mws_flags_t                     e_flags_o
);
  import mws_pkg::*;

  logic signed [SumW-1:0] pmem [MAX_ROWS][MAX_COLS];
  logic signed [SumW-1:0] qbuf [MAX_COLS];

  // stage B
  logic                    b_valid_q;
  logic signed [CellW-1:0] b_cell_q;
  logic [RW-1:0]           b_row_q, b_far_q;
  logic [CW-1:0]           b_col_q, b_old_q;
  mws_flags_t              b_flags_q;
  logic signed [SumW-1:0]  cell_ext, rp_d, rp_q;
  logic [RW-1:0]           up_row;
  logic                    byp_d;

  // stage C
  logic                    c_valid_q;
  logic signed [SumW-1:0]  c_rp_q, up_rd_q, up_eff, p_d;
  logic                    byp_q;
  logic [RW-1:0]           c_row_q, c_far_q;
  logic [CW-1:0]           c_col_q, c_old_q;
  mws_flags_t              c_flags_q;

  // stage D
  logic                    d_valid_q;
  logic signed [SumW-1:0]  p_q, far_rd_q, q_d;
  logic [CW-1:0]           d_col_q, d_old_q;
  mws_flags_t              d_flags_q;

  // stage E
  logic                    e_valid_q;
  logic signed [SumW-1:0]  e_q_q, e_qold_q;
  mws_flags_t              e_flags_q;

  assign cell_ext = {{(SumW-CellW){b_cell_q[CellW-1]}}, b_cell_q};
  assign rp_d     = (b_flags_q.c_gt0 ? rp_q : '0) + cell_ext;
  assign up_row   = b_row_q - RW'(1);
  // previous cell still in C writes the entry we read at this edge
  assign byp_d    = c_valid_q && (c_row_q == up_row) && (c_col_q == b_col_q);

  always_comb begin
    if (!c_flags_q.r_gt0) begin
      up_eff = '0;
    end else if (byp_q) begin
      up_eff = p_q;
    end else begin
      up_eff = up_rd_q;
    end
  end
  assign p_d = up_eff + c_rp_q;
  assign q_d = p_q - (d_flags_q.r_ge_wh ? far_rd_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else begin
      b_valid_q <= acc_i;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      b_cell_q  <= cell_i;
      b_row_q   <= row_i;
      b_col_q   <= col_i;
      b_far_q   <= far_row_i;
      b_old_q   <= old_col_i;
      b_flags_q <= flags_i;
    end
    if (b_valid_q) begin
      rp_q      <= rp_d;
      c_rp_q    <= rp_d;
      byp_q     <= byp_d;
      c_row_q   <= b_row_q;
      c_col_q   <= b_col_q;
      c_far_q   <= b_far_q;
      c_old_q   <= b_old_q;
      c_flags_q <= b_flags_q;
    end
    if (c_valid_q) begin
      p_q       <= p_d;
      d_col_q   <= c_col_q;
      d_old_q   <= c_old_q;
      d_flags_q <= c_flags_q;
    end
    if (d_valid_q) begin
      e_q_q     <= q_d;
      e_flags_q <= d_flags_q;
    end
  end

  // summed-area table: two reads, one write per cycle
  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      up_rd_q <= pmem[up_row][b_col_q];
    end
    if (c_valid_q) begin
      pmem[c_row_q][c_col_q] <= p_d;
      far_rd_q               <= pmem[c_far_q][c_col_q];
    end
  end

  // strip sums of the current row
  always_ff @(posedge clk_i) begin
    if (d_valid_q) begin
      qbuf[d_col_q] <= q_d;
      e_qold_q      <= qbuf[d_old_q];
    end
  end

  assign e_valid_o = e_valid_q;
  assign e_q_o     = e_q_q;
  assign e_qold_o  = e_qold_q;
  assign e_flags_o = e_flags_q;

endmodule

/* rtl/mws_best.sv */
// Window sum, running maximum and the result register.
// Depends on mws_pkg and mws_if.
module mws_best (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            e_valid_i,
  input  logic signed [mws_pkg::SumW-1:0] e_q_i,
  input  logic signed [mws_pkg::SumW-1:0] e_qold_i,
  input  mws_pkg::mws_flags_t             e_flags_i,
  mws_result_if.source                    result_o
);
  import mws_pkg::*;

  logic signed [SumW-1:0] win_sum, best_d, best_q, out_best_q;
  logic                   seen_d, seen_q, upd, out_valid_q, out_found_q;
  logic                   fin;

  assign win_sum = e_q_i - (e_flags_i.c_ge_ww ? e_qold_i : '0);
  assign upd     = e_flags_i.win_ok && (!seen_q || (win_sum > best_q));
  assign best_d  = upd ? win_sum : best_q;
  assign seen_d  = seen_q | e_flags_i.win_ok;
  assign fin     = e_valid_i && e_flags_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= IntMin;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin) begin
        best_q <= IntMin;
        seen_q <= 1'b0;
      end else if (e_valid_i) begin
        best_q <= best_d;
        seen_q <= seen_d;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_best_q  <= best_d;
      out_found_q <= seen_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.best_sum     = out_best_q;
  assign result_o.window_found = out_found_q;

endmodule

/* rtl/max_window_sum_2d.sv */
// Largest fixed-size rectangle sum over a raster-order signed grid.
// Top level: config registers, raster position, geometry latch, flow control.
// Depends on mws_pkg, mws_if, mws_prefix, mws_best.
//
//   channel   dir  interface      payload
//   cell_i    in   mws_cell_if    cell_value (16b signed)
//   result_o  out  mws_result_if  best_sum (32b signed), window_found
//   cfg_*     in   write port     cfg_idx_i (3b), cfg_wdata_i (7b)
//
// One cell per cycle while cell_i.ready is high; the result of a grid is registered after
// its last cell passes stages B to E. The last cell of a grid is held off until the previous
// result has been taken (or is taken in that cycle); other cells are not held.
// Geometry is latched from the config registers when a grid's first cell enters.
// Reset clears position and running maximum; prefix memory needs no clearing.
module max_window_sum_2d #(
  parameter int unsigned MAX_ROWS = mws_pkg::DefMaxRows,
  parameter int unsigned MAX_COLS = mws_pkg::DefMaxCols,
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int unsigned HW    = $clog2(MAX_ROWS + 1),
  localparam int unsigned WW    = $clog2(MAX_COLS + 1),
  localparam int unsigned CmpRW = (HW > mws_pkg::CfgDataW) ? HW : mws_pkg::CfgDataW,
  localparam int unsigned CmpCW = (WW > mws_pkg::CfgDataW) ? WW : mws_pkg::CfgDataW
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mws_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mws_pkg::CfgDataW-1:0]   cfg_wdata_i,
  mws_cell_if.sink                       cell_i,
  mws_result_if.source                   result_o
);
  import mws_pkg::*;

  function automatic logic [HW-1:0] clamp_h(logic [CfgDataW-1:0] v);
    logic [CmpRW-1:0] x;
    x = CmpRW'(v);
    if (x == '0) begin
      return HW'(1);
    end else if (x > CmpRW'(MAX_ROWS)) begin
      return HW'(MAX_ROWS);
    end
    return HW'(x);
  endfunction

  function automatic logic [WW-1:0] clamp_w(logic [CfgDataW-1:0] v);
    logic [CmpCW-1:0] x;
    x = CmpCW'(v);
    if (x == '0) begin
      return WW'(1);
    end else if (x > CmpCW'(MAX_COLS)) begin
      return WW'(MAX_COLS);
    end
    return WW'(x);
  endfunction

  logic [CfgDataW-1:0] grid_h_q, grid_w_q, win_h_q, win_w_q;
  logic [HW-1:0]       act_rows_q, act_wh_q, eff_rows, eff_wh, r_ext;
  logic [WW-1:0]       act_cols_q, act_ww_q, eff_cols, eff_ww, c_ext;
  logic [RW-1:0]       row_q, far_row;
  logic [CW-1:0]       col_q, old_col;
  logic                at_origin, last_col, last_row, cur_last;
  logic                pending_q, in_ready, acc, res_take;
  mws_flags_t          flags;

  logic                e_valid;
  logic signed [SumW-1:0] e_q, e_qold;
  mws_flags_t          e_flags;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_h_q <= GridHeightRst;
      grid_w_q <= GridWidthRst;
      win_h_q  <= WindowHeightRst;
      win_w_q  <= WindowWidthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_HEIGHT:   grid_h_q <= cfg_wdata_i;
        CFG_GRID_WIDTH:    grid_w_q <= cfg_wdata_i;
        CFG_WINDOW_HEIGHT: win_h_q  <= cfg_wdata_i;
        CFG_WINDOW_WIDTH:  win_w_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign at_origin = (row_q == '0) && (col_q == '0);
  assign eff_rows  = at_origin ? clamp_h(grid_h_q) : act_rows_q;
  assign eff_wh    = at_origin ? clamp_h(win_h_q)  : act_wh_q;
  assign eff_cols  = at_origin ? clamp_w(grid_w_q) : act_cols_q;
  assign eff_ww    = at_origin ? clamp_w(win_w_q)  : act_ww_q;

  assign r_ext    = HW'(row_q);
  assign c_ext    = WW'(col_q);
  assign last_row = (r_ext + HW'(1)) == eff_rows;
  assign last_col = (c_ext + WW'(1)) == eff_cols;
  assign cur_last = last_row && last_col;
  assign far_row  = RW'(r_ext - eff_wh);
  assign old_col  = CW'(c_ext - eff_ww);

  always_comb begin
    flags.r_gt0   = (row_q != '0);
    flags.c_gt0   = (col_q != '0);
    flags.r_ge_wh = (r_ext >= eff_wh);
    flags.c_ge_ww = (c_ext >= eff_ww);
    flags.win_ok  = ((r_ext + HW'(1)) >= eff_wh) && ((c_ext + WW'(1)) >= eff_ww);
    flags.last    = cur_last;
  end

  assign res_take     = result_o.valid && result_o.ready;
  assign in_ready     = !cur_last || !pending_q || res_take;
  assign cell_i.ready = in_ready;
  assign acc          = cell_i.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      pending_q <= 1'b0;
    end else begin
      if (acc) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (acc && cur_last) begin
        pending_q <= 1'b1;
      end else if (res_take) begin
        pending_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && at_origin) begin
      act_rows_q <= eff_rows;
      act_cols_q <= eff_cols;
      act_wh_q   <= eff_wh;
      act_ww_q   <= eff_ww;
    end
  end

  mws_prefix #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_prefix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .cell_i    (cell_i.cell_value),
    .row_i     (row_q),
    .col_i     (col_q),
    .far_row_i (far_row),
    .old_col_i (old_col),
    .flags_i   (flags),
    .e_valid_o (e_valid),
    .e_q_o     (e_q),
    .e_qold_o  (e_qold),
    .e_flags_o (e_flags)
  );

  mws_best u_best (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .e_valid_i (e_valid),
    .e_q_i     (e_q),
    .e_qold_i  (e_qold),
    .e_flags_i (e_flags),
    .result_o  (result_o)
  );

endmodule

/* rtl/mws_checker.sv */
// Port-level checks for max_window_sum_2d, attached by bind.
// Depends on mws_pkg and max_window_sum_2d.
module mws_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            res_valid_i,
  input logic                            res_ready_i,
  input logic signed [mws_pkg::SumW-1:0] res_best_i,
  input logic                            res_found_i
);
  import mws_pkg::*;

  // stalled result transaction holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_best_i) && $stable(res_found_i))
    else $error("result changed while stalled");

  a_no_window_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_found_i |-> res_best_i == IntMin)
    else $error("no window but best_sum is not the minimum");

  // one result in flight at most: a fresh one cannot follow directly
  a_res_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i |=> !res_valid_i)
    else $error("result followed a transaction without a gap");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

endmodule

bind max_window_sum_2d mws_checker u_mws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .res_best_i  (result_o.best_sum),
  .res_found_i (result_o.window_found)
);
